@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace core.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 4;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIND_PATTERN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIND_LENGTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_PATTERN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH  = 2'd3;

	// control part of the result burst produced for one input byte
	typedef struct packed {
		logic [CNT_W-1:0] n;      // number of output words
		logic             last;   // final word closes the text
		logic             nochar; // single end marker without a byte
	} res_ctl_t;

endpackage

`default_nettype wire

@@ rtl/sfr_step.sv @@
// ----------------------------------------------------------------------------
// sfr_step
// Holds the byte window and turns one input byte into a burst of output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_step import sfr_pkg::*; #(
	parameter int FIND_MAX    = 8,
	parameter int REPLACE_MAX = 8,
	parameter int BURST_MAX   = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic [CHAR_W-1:0]                   in_char,
	input  wire logic                                in_last,
	input  wire logic [CFG_DATA_W-1:0]               find_pattern,
	input  wire logic [LEN_W-1:0]                    find_length,
	input  wire logic [CFG_DATA_W-1:0]               replace_pattern,
	input  wire logic [LEN_W-1:0]                    replace_length,
	output logic      [BURST_MAX-1:0][CHAR_W-1:0]    res_bytes,
	output res_ctl_t                                 res_ctl
);

	logic [FIND_MAX-1:0][CHAR_W-1:0] win_q;
	logic [CNT_W-1:0]                win_cnt_q;

	logic [FIND_MAX-1:0][CHAR_W-1:0] w;
	logic [FIND_MAX-1:0][CHAR_W-1:0] win_next;
	logic [CNT_W-1:0]                cnt_next;
	logic [CNT_W-1:0]                c1;
	logic [CNT_W-1:0]                flen;
	logic [CNT_W-1:0]                rlen;
	logic [CNT_W-1:0]                k;
	logic                            match;
	logic                            full_match;

	always_comb begin
		c1 = win_cnt_q + CNT_W'(1);

		if (find_length == '0) begin
			flen = CNT_W'(1);
		end else if (find_length > LEN_W'(FIND_MAX)) begin
			flen = CNT_W'(FIND_MAX);
		end else begin
			flen = CNT_W'(find_length);
		end

		if (replace_length > LEN_W'(REPLACE_MAX)) begin
			rlen = CNT_W'(REPLACE_MAX);
		end else begin
			rlen = CNT_W'(replace_length);
		end

		// window after the push: held bytes, then the new byte
		for (int i = 0; i < FIND_MAX; i++) begin
			w[i] = (CNT_W'(i) < win_cnt_q) ? win_q[i] : in_char;
		end

		match = 1'b1;
		for (int j = 0; j < FIND_MAX; j++) begin
			if (CNT_W'(j) < flen && w[j] != find_pattern[8*j +: 8]) begin
				match = 1'b0;
			end
		end
		full_match = (c1 == flen) && match;

		// number of oldest bytes to release
		if (full_match) begin
			k = '0;
		end else if (in_last) begin
			k = c1;
		end else if (c1 >= flen) begin
			k = c1 - flen + CNT_W'(1);
		end else begin
			k = '0;
		end

		cnt_next = (in_last || full_match) ? '0 : c1 - k;

		win_next = w;
		for (int s = 1; s <= FIND_MAX; s++) begin
			if (k == CNT_W'(s)) begin
				for (int i = 0; i < FIND_MAX; i++) begin
					win_next[i] = (i + s < FIND_MAX) ? w[(i + s) % FIND_MAX] : '0;
				end
			end
		end

		res_bytes = '0;
		if (full_match) begin
			for (int i = 0; i < REPLACE_MAX; i++) begin
				res_bytes[i] = replace_pattern[8*i +: 8];
			end
			res_ctl.n = rlen;
		end else begin
			for (int i = 0; i < FIND_MAX; i++) begin
				res_bytes[i] = w[i];
			end
			res_ctl.n = k;
		end
		res_ctl.last   = in_last;
		res_ctl.nochar = 1'b0;
		// last byte with nothing to send: emit a bare end marker
		if (in_last && res_ctl.n == '0) begin
			res_ctl.n      = CNT_W'(1);
			res_ctl.nochar = 1'b1;
			res_bytes      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q <= '0;
		end else if (accept) begin
			win_cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= win_next;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> win_cnt_q == '0)
		else $error("window not emptied after last byte");

	a_window_short: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_last |=> win_cnt_q < $past(flen))
		else $error("window holds a full pattern after a step");

	a_last_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |-> res_ctl.n != '0)
		else $error("last byte produced no output word");

endmodule

`default_nettype wire

@@ rtl/sfr_emit.sv @@
// ----------------------------------------------------------------------------
// sfr_emit
// Burst buffer and output register; drains one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_emit import sfr_pkg::*; #(
	parameter int BURST_MAX = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic [BURST_MAX-1:0][CHAR_W-1:0] res_bytes,
	input  wire res_ctl_t                         res_ctl,
	output logic                                  in_ready,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [CHAR_W-1:0]                m_tdata,  // out_char
	output logic                                  m_tuser,  // has_char
	output logic                                  m_tlast   // out_last
);

	logic [BURST_MAX-1:0][CHAR_W-1:0] burst_q;
	logic [CNT_W-1:0]                 rem_q;
	logic                             blast_q;
	logic                             bnochar_q;

	logic                             valid_q;
	logic [CHAR_W-1:0]                char_q;
	logic                             has_q;
	logic                             last_q;

	logic [BURST_MAX-1:0][CHAR_W-1:0] src;
	logic [BURST_MAX-1:0][CHAR_W-1:0] shifted;
	logic [CNT_W-1:0]                 src_n;
	logic                             src_last;
	logic                             src_nochar;
	logic                             take;
	logic                             pop;

	always_comb begin
		take = !valid_q || m_tready;
		// a new burst only arrives while the buffer is empty
		if (accept) begin
			src        = res_bytes;
			src_n      = res_ctl.n;
			src_last   = res_ctl.last;
			src_nochar = res_ctl.nochar;
		end else begin
			src        = burst_q;
			src_n      = rem_q;
			src_last   = blast_q;
			src_nochar = bnochar_q;
		end
		pop = take && (src_n != '0);
		shifted = '0;
		for (int i = 0; i + 1 < BURST_MAX; i++) begin
			shifted[i] = src[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			rem_q <= pop ? src_n - CNT_W'(1) : src_n;
			if (take) begin
				valid_q <= pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		burst_q   <= pop ? shifted : src;
		blast_q   <= src_last;
		bnochar_q <= src_nochar;
		if (pop) begin
			char_q <= src[0];
			has_q  <= !src_nochar;
			last_q <= src_last && (src_n == CNT_W'(1));
		end
	end

	assign in_ready = (rem_q == '0);
	assign m_tvalid = valid_q;
	assign m_tdata  = char_q;
	assign m_tuser  = has_q;
	assign m_tlast  = last_q;

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("end marker without last flag");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("end marker carries a nonzero byte");

	a_burst_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != '0 |-> valid_q)
		else $error("buffered words while output register is empty");

endmodule

`default_nettype wire

@@ rtl/stream_find_and_replace_core.sv @@
// ----------------------------------------------------------------------------
// stream_find_and_replace_core
// Streaming substring find-and-replace over a byte stream.
// ----------------------------------------------------------------------------
// Text bytes enter on the s_ stream, one per word, s_tlast on the final byte.
// Each non-overlapping match of the find pattern (1 to FIND_MAX bytes) is
// replaced by the replace string (0 to REPLACE_MAX bytes); replaced text is not
// searched again. Up to FIND_MAX-1 recent bytes are held back until they can be
// decided. Each accepted byte yields 0 to max(FIND_MAX, REPLACE_MAX) output
// words. The single output port sends one word per cycle, so the core takes one
// byte per cycle while m_tready is high and each byte releases at most one word;
// a byte that releases more holds s_tready low while the result buffer drains. A
// last byte that leaves nothing to send yields one word with m_tuser low, data
// zero and m_tlast high. Configuration is written through cfg_we / cfg_index /
// cfg_data by the user only while the core is idle; the core leaves it unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_and_replace_core import sfr_pkg::*; #(
	parameter int FIND_MAX    = 8,
	parameter int REPLACE_MAX = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // in_char
	input  wire logic                  s_tlast,   // in_last
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [7:0]            m_tdata,   // out_char
	output logic                       m_tuser,   // has_char
	output logic                       m_tlast    // out_last
);

	localparam int BURST_MAX = (FIND_MAX > REPLACE_MAX) ? FIND_MAX : REPLACE_MAX;

	logic [CFG_DATA_W-1:0] find_pattern_q;
	logic [LEN_W-1:0]      find_length_q;
	logic [CFG_DATA_W-1:0] replace_pattern_q;
	logic [LEN_W-1:0]      replace_length_q;

	logic                             accept;
	logic [BURST_MAX-1:0][CHAR_W-1:0] res_bytes;
	res_ctl_t                         res_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_pattern_q    <= '0;
			find_length_q     <= LEN_W'(1);
			replace_pattern_q <= '0;
			replace_length_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIND_PATTERN:    find_pattern_q    <= cfg_data;
				REG_FIND_LENGTH:     find_length_q     <= cfg_data[LEN_W-1:0];
				REG_REPLACE_PATTERN: replace_pattern_q <= cfg_data;
				REG_REPLACE_LENGTH:  replace_length_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = s_tvalid && s_tready;

	sfr_step #(
		.FIND_MAX    (FIND_MAX),
		.REPLACE_MAX (REPLACE_MAX),
		.BURST_MAX   (BURST_MAX)
	) u_step (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.in_char         (s_tdata),
		.in_last         (s_tlast),
		.find_pattern    (find_pattern_q),
		.find_length     (find_length_q),
		.replace_pattern (replace_pattern_q),
		.replace_length  (replace_length_q),
		.res_bytes       (res_bytes),
		.res_ctl         (res_ctl)
	);

	sfr_emit #(
		.BURST_MAX (BURST_MAX)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.res_bytes (res_bytes),
		.res_ctl   (res_ctl),
		.in_ready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire
